FILE: design/pcis_pkg.sv
// Package for packet_class_interval_stats: widths, class codes, protocol constants
// and the controller/datapath command and status structs. No dependencies.
package pcis_pkg;
    localparam int NUM_CLASSES        = 5;
    localparam int DEF_INTERVAL_SLOTS = 10;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] IP_ETH_HDR_LEN = 16'd34;
    localparam logic [2:0] CLS_TOTAL = 3'd0;
    localparam logic [2:0] CLS_IPV4  = 3'd1;
    localparam logic [2:0] CLS_TCP   = 3'd2;
    localparam logic [2:0] CLS_UDP   = 3'd3;
    localparam logic [2:0] CLS_IPV6  = 3'd4;
    localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic load;     // capture request, decide report
        logic clear;    // step clear sweep
        logic rd;       // issue memory read of report cursor
        logic upd;      // update class given by upd_cls
        logic [2:0] upd_cls;
    } dp_cmd_t;

    typedef struct packed {
        logic report;   // captured request triggers a report
        logic [4:0] cls_mask;
        logic sweep_done;
    } dp_stat_t;
endpackage

FILE: design/packet_class_interval_stats.sv
// Per-interval packet statistics by class (total, IPv4, TCP, UDP, IPv6). One request
// at a time: a plain request is accepted, then decided, then takes one step per class
// and one write-back step per matching class on the slot memories (one read and one
// write port). A request that closes an interval first sends 5*(INTERVAL_SLOTS+1)
// results, each read and then emitted, then a clear sweep of the 5*INTERVAL_SLOTS slot
// entries. After reset the same sweep runs before the first request is taken.
module packet_class_interval_stats import pcis_pkg::*; #(
    parameter int INTERVAL_SLOTS = DEF_INTERVAL_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_cap_len,
    input  logic [15:0] s_wire_len,
    input  logic [15:0] s_eth_type,
    input  logic [7:0]  s_ip_proto,
    input  logic [31:0] s_ts_sec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_class_id,
    output logic [3:0]  m_slot,
    output logic [31:0] m_packets,
    output logic [47:0] m_bytes,
    output logic [15:0] m_min_len,
    output logic [15:0] m_max_len,
    output logic        m_last
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [2:0]  rd_cls;
    logic [3:0]  rd_slot;
    logic [31:0] rd_packets, rd_cls_packets;
    logic [47:0] rd_bytes, rd_cls_bytes;
    logic [15:0] rd_min, rd_max;
    logic        out_load, out_summary, out_last, out_free;

    pcis_ctrl #(.INTERVAL_SLOTS(INTERVAL_SLOTS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .cmd, .stat, .rd_cls, .rd_slot,
        .out_load, .out_summary, .out_last, .out_free
    );

    pcis_datapath #(.INTERVAL_SLOTS(INTERVAL_SLOTS)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .cap_len(s_cap_len), .wire_len(s_wire_len), .eth_type(s_eth_type),
        .ip_proto(s_ip_proto), .ts_sec(s_ts_sec),
        .rd_cls, .rd_slot, .rd_packets, .rd_bytes, .rd_cls_packets, .rd_cls_bytes,
        .rd_min, .rd_max
    );

    assign out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_class_id <= rd_cls;
            m_slot     <= rd_slot;
            m_packets  <= out_summary ? rd_cls_packets : rd_packets;
            m_bytes    <= out_summary ? rd_cls_bytes : rd_bytes;
            m_min_len  <= out_summary ? rd_min : 16'd0;
            m_max_len  <= out_summary ? rd_max : 16'd0;
            m_last     <= out_last;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !out_load) else $error("result produced while idle");
    a_last_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_slot == 4'(INTERVAL_SLOTS)) else $error("last not summary");
    a_upd_no_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.upd && cmd.clear)) else $error("update during clear");
endmodule

FILE: design/pcis_datapath.sv
// Datapath: request registers, class tables, slot memories, report read-out.
// Depends on pcis_pkg.
module pcis_datapath import pcis_pkg::*; #(
    parameter int INTERVAL_SLOTS = DEF_INTERVAL_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [15:0] cap_len,
    input  logic [15:0] wire_len,
    input  logic [15:0] eth_type,
    input  logic [7:0]  ip_proto,
    input  logic [31:0] ts_sec,
    input  logic [2:0]  rd_cls,
    input  logic [3:0]  rd_slot,
    output logic [31:0] rd_packets,
    output logic [47:0] rd_bytes,
    output logic [31:0] rd_cls_packets,
    output logic [47:0] rd_cls_bytes,
    output logic [15:0] rd_min,
    output logic [15:0] rd_max
);
    localparam int DEPTH = NUM_CLASSES * INTERVAL_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0] slot_pk_mem [DEPTH];
    logic [47:0] slot_by_mem [DEPTH];
    logic [31:0] cls_pk_reg  [NUM_CLASSES];
    logic [47:0] cls_by_reg  [NUM_CLASSES];
    logic [15:0] cls_min_reg [NUM_CLASSES];
    logic [15:0] cls_max_reg [NUM_CLASSES];

    logic        started_reg;
    logic [31:0] base_reg;
    logic [15:0] len_reg;
    logic        win_reg;
    logic [3:0]  idx_reg;
    logic [4:0]  mask_reg;
    logic        report_reg;
    logic [AW-1:0] sweep_reg;

    logic [31:0] base_eff, diff;
    logic        trig;
    logic [4:0]  mask_c;

    always_comb begin
        base_eff = started_reg ? base_reg : ts_sec;
        diff     = ts_sec - base_eff;
        trig     = (ts_sec >= base_eff) && (diff >= 32'(INTERVAL_SLOTS));
        mask_c   = 5'b00001;
        if (cap_len > ETH_HDR_LEN) begin
            if (eth_type == ETYPE_IPV4) begin
                mask_c[CLS_IPV4] = 1'b1;
                if (cap_len > IP_ETH_HDR_LEN) begin
                    mask_c[CLS_TCP] = (ip_proto == PROTO_TCP);
                    mask_c[CLS_UDP] = (ip_proto == PROTO_UDP);
                end
            end else if (eth_type == ETYPE_IPV6) begin
                mask_c[CLS_IPV6] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            base_reg    <= '0;
        end else if (cmd.load) begin
            started_reg <= 1'b1;
            if (!started_reg || trig) base_reg <= ts_sec;
        end
    end

    // request fields; window test done against the base after any rebase
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            len_reg    <= wire_len;
            mask_reg   <= mask_c;
            report_reg <= trig;
            if (!started_reg || trig) begin
                win_reg <= 1'b1;
                idx_reg <= '0;
            end else begin
                win_reg <= (ts_sec >= base_reg) && (diff < 32'(INTERVAL_SLOTS));
                idx_reg <= diff[3:0];
            end
        end
    end

    assign stat.report     = report_reg;
    assign stat.cls_mask   = mask_reg;
    assign stat.sweep_done = (sweep_reg == AW'(DEPTH - 1));

    logic [AW-1:0] upd_addr, rd_addr;
    logic [31:0]   upd_pk;
    logic [47:0]   upd_by;
    logic [AW-1:0] uaddr_reg;
    logic [48:0]   by_sum;
    logic [48:0]   cb_sum;
    logic          upd_d_reg;

    assign upd_addr = AW'(32'(cmd.upd_cls) * INTERVAL_SLOTS + 32'(idx_reg));
    assign rd_addr  = AW'(32'(rd_cls) * INTERVAL_SLOTS + 32'(rd_slot));

    // slot memories: one read, one write port; clear sweep after reports and reset
    // read data holds between reads so a stalled result keeps its figures
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            slot_pk_mem[sweep_reg] <= '0;
            slot_by_mem[sweep_reg] <= '0;
        end else if (upd_d_reg) begin
            slot_pk_mem[uaddr_reg] <= upd_pk;
            slot_by_mem[uaddr_reg] <= upd_by;
        end
        if (cmd.rd) begin
            rd_packets <= slot_pk_mem[rd_addr];
            rd_bytes   <= slot_by_mem[rd_addr];
        end else if (cmd.upd) begin
            rd_packets <= slot_pk_mem[upd_addr];
            rd_bytes   <= slot_by_mem[upd_addr];
        end
    end

    // update: read issued in upd cycle, write-back in the cycle after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_d_reg <= 1'b0;
        end else begin
            upd_d_reg <= cmd.upd && win_reg;
        end
        uaddr_reg <= upd_addr;
    end
    assign by_sum = {1'b0, rd_bytes} + 49'(len_reg);
    assign upd_pk = (rd_packets == PKT_MAX) ? rd_packets : rd_packets + 32'd1;
    assign upd_by = by_sum[48] ? BYTE_MAX : by_sum[47:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.clear) begin
            sweep_reg <= stat.sweep_done ? '0 : sweep_reg + AW'(1);
        end
    end

    assign cb_sum = {1'b0, cls_by_reg[cmd.upd_cls]} + 49'(len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                cls_pk_reg[c]  <= '0;
                cls_by_reg[c]  <= '0;
                cls_min_reg[c] <= 16'hFFFF;
                cls_max_reg[c] <= '0;
            end
        end else if (cmd.clear && sweep_reg == '0) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                cls_pk_reg[c]  <= '0;
                cls_by_reg[c]  <= '0;
                cls_min_reg[c] <= 16'hFFFF;
                cls_max_reg[c] <= '0;
            end
        end else if (cmd.upd) begin
            if (cls_pk_reg[cmd.upd_cls] != PKT_MAX)
                cls_pk_reg[cmd.upd_cls] <= cls_pk_reg[cmd.upd_cls] + 32'd1;
            cls_by_reg[cmd.upd_cls] <= cb_sum[48] ? BYTE_MAX : cb_sum[47:0];
            if (len_reg < cls_min_reg[cmd.upd_cls]) cls_min_reg[cmd.upd_cls] <= len_reg;
            if (len_reg > cls_max_reg[cmd.upd_cls]) cls_max_reg[cmd.upd_cls] <= len_reg;
        end
    end

    assign rd_cls_packets = cls_pk_reg[rd_cls];
    assign rd_cls_bytes   = cls_by_reg[rd_cls];
    assign rd_min = cls_min_reg[rd_cls];
    assign rd_max = cls_max_reg[rd_cls];
endmodule

FILE: design/pcis_ctrl.sv
// Controller: sequences accept, report run, clear sweep and per-class updates.
// Depends on pcis_pkg.
module pcis_ctrl import pcis_pkg::*; #(
    parameter int INTERVAL_SLOTS = DEF_INTERVAL_SLOTS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat,
    output logic [2:0] rd_cls,
    output logic [3:0] rd_slot,
    output logic       out_load,
    output logic       out_summary,
    output logic       out_last,
    input  logic       out_free
);
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_RD     = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_SWEEP  = 7'b0100000,
        S_UPD    = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cls_reg, cls_next;
    logic [3:0] slot_reg, slot_next;
    logic       upd_gap_reg, upd_gap_next;

    assign rd_cls  = cls_reg;
    assign rd_slot = slot_reg;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cls_next     = cls_reg;
        slot_next    = slot_reg;
        upd_gap_next = 1'b0;
        cmd          = '0;
        out_load     = 1'b0;
        out_summary  = (slot_reg == 4'(INTERVAL_SLOTS));
        out_last     = out_summary && (cls_reg == CLS_IPV6);
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.sweep_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cls_next  = CLS_TOTAL;
                slot_next = '0;
                state_next = stat.report ? S_RD : S_UPD;
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last) begin
                        cls_next   = CLS_TOTAL;
                        state_next = S_SWEEP;
                    end else begin
                        if (out_summary) begin
                            slot_next = '0;
                            cls_next  = cls_reg + 3'd1;
                        end else begin
                            slot_next = slot_reg + 4'd1;
                        end
                        state_next = S_RD;
                    end
                end
            end
            S_SWEEP: begin
                cmd.clear = 1'b1;
                if (stat.sweep_done) state_next = S_UPD;
            end
            S_UPD: begin
                // matching class: memory read, then a write-back step; others pass straight on
                if (upd_gap_reg) begin
                    if (cls_reg == CLS_IPV6) state_next = S_IDLE;
                    cls_next = cls_reg + 3'd1;
                end else if (stat.cls_mask[cls_reg]) begin
                    cmd.upd      = 1'b1;
                    cmd.upd_cls  = cls_reg;
                    upd_gap_next = 1'b1;
                end else begin
                    if (cls_reg == CLS_IPV6) state_next = S_IDLE;
                    cls_next = cls_reg + 3'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cls_reg     <= '0;
            slot_reg    <= '0;
            upd_gap_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cls_reg     <= cls_next;
            slot_reg    <= slot_next;
            upd_gap_reg <= upd_gap_next;
        end
    end
endmodule

FILE: tb/pcis_checker.sv
// Checker for packet_class_interval_stats: watches both channels, keeps its own copy
// of the per-class interval figures and compares every report result. Uses pcis_pkg.
`timescale 1ns / 100ps
module pcis_checker import pcis_pkg::*; #(
    parameter int INTERVAL_SLOTS = DEF_INTERVAL_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_cap_len,
    input  logic [15:0] s_wire_len,
    input  logic [15:0] s_eth_type,
    input  logic [7:0]  s_ip_proto,
    input  logic [31:0] s_ts_sec,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_class_id,
    input  logic [3:0]  m_slot,
    input  logic [31:0] m_packets,
    input  logic [47:0] m_bytes,
    input  logic [15:0] m_min_len,
    input  logic [15:0] m_max_len,
    input  logic        m_last,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [2:0]  class_id;
        logic [3:0]  slot;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [15:0] min_len;
        logic [15:0] max_len;
        logic        last;
    } report_t;

    localparam int NSLOT = NUM_CLASSES * INTERVAL_SLOTS;

    report_t     report_q[$];
    logic        seen_first;
    logic [31:0] base_ts;
    logic [31:0] cls_pkts[NUM_CLASSES];
    logic [47:0] cls_bytes[NUM_CLASSES];
    logic [15:0] cls_min[NUM_CLASSES];
    logic [15:0] cls_max[NUM_CLASSES];
    logic [31:0] sec_pkts[NSLOT];
    logic [47:0] sec_bytes[NSLOT];

    assign pending = report_q.size();

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == PKT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [47:0] sat_add(logic [47:0] v, logic [15:0] n);
        logic [48:0] s;
        s = {1'b0, v} + n;
        return s[48] ? BYTE_MAX : s[47:0];
    endfunction

    task automatic clear_figures();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cls_pkts[c] = '0;
            cls_bytes[c] = '0;
            cls_min[c] = 16'hFFFF;
            cls_max[c] = '0;
        end
        for (int k = 0; k < NSLOT; k++) begin
            sec_pkts[k] = '0;
            sec_bytes[k] = '0;
        end
    endtask

    task automatic tally(int c, logic [15:0] len, logic win, logic [31:0] idx);
        int k;
        cls_pkts[c] = sat_inc(cls_pkts[c]);
        cls_bytes[c] = sat_add(cls_bytes[c], len);
        if (len < cls_min[c]) cls_min[c] = len;
        if (len > cls_max[c]) cls_max[c] = len;
        if (win && idx < INTERVAL_SLOTS) begin
            k = c * INTERVAL_SLOTS + int'(idx);
            sec_pkts[k] = sat_inc(sec_pkts[k]);
            sec_bytes[k] = sat_add(sec_bytes[k], len);
        end
    endtask

    task automatic queue_report();
        report_t r;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int s = 0; s < INTERVAL_SLOTS; s++) begin
                r = '{3'(c), 4'(s), sec_pkts[c*INTERVAL_SLOTS+s],
                      sec_bytes[c*INTERVAL_SLOTS+s], 16'd0, 16'd0, 1'b0};
                report_q.push_back(r);
            end
            r = '{3'(c), 4'(INTERVAL_SLOTS), cls_pkts[c], cls_bytes[c], cls_min[c],
                  cls_max[c], c == NUM_CLASSES - 1};
            report_q.push_back(r);
        end
    endtask

    task automatic take_packet(logic [15:0] cap, logic [15:0] len, logic [15:0] et,
                               logic [7:0] proto, logic [31:0] ts);
        logic        win;
        logic [31:0] idx;
        if (!seen_first) begin
            seen_first = 1'b1;
            base_ts = ts;
        end
        if (ts >= base_ts && ts - base_ts >= INTERVAL_SLOTS) begin
            queue_report();
            clear_figures();
            base_ts = ts;
        end
        win = ts >= base_ts;
        idx = win ? ts - base_ts : 32'd0;
        tally(CLS_TOTAL, len, win, idx);
        if (cap > ETH_HDR_LEN) begin
            if (et == ETYPE_IPV4) begin
                if (cap > IP_ETH_HDR_LEN) begin
                    if (proto == PROTO_TCP) tally(CLS_TCP, len, win, idx);
                    else if (proto == PROTO_UDP) tally(CLS_UDP, len, win, idx);
                end
                tally(CLS_IPV4, len, win, idx);
            end else if (et == ETYPE_IPV6) begin
                tally(CLS_IPV6, len, win, idx);
            end
        end
    endtask

    task automatic check_result();
        report_t e;
        if (report_q.size() == 0) begin
            $error("unexpected result class %0d slot %0d", m_class_id, m_slot);
            fail_count++;
            return;
        end
        e = report_q.pop_front();
        if (m_class_id !== e.class_id) begin
            $error("class_id exp %0d got %0d", e.class_id, m_class_id); fail_count++;
        end
        if (m_slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, m_slot); fail_count++;
        end
        if (m_packets !== e.packets) begin
            $error("packets exp %0d got %0d", e.packets, m_packets); fail_count++;
        end
        if (m_bytes !== e.bytes) begin
            $error("bytes exp %0d got %0d", e.bytes, m_bytes); fail_count++;
        end
        if (m_min_len !== e.min_len) begin
            $error("min_len exp %0d got %0d", e.min_len, m_min_len); fail_count++;
        end
        if (m_max_len !== e.max_len) begin
            $error("max_len exp %0d got %0d", e.max_len, m_max_len); fail_count++;
        end
        if (m_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_last); fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            seen_first = 1'b0;
            base_ts = '0;
            report_q.delete();
            clear_figures();
        end else begin
            // result check first: a request closing an interval cannot emit in its own cycle
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready)
                take_packet(s_cap_len, s_wire_len, s_eth_type, s_ip_proto, s_ts_sec);
        end
    end
endmodule

FILE: tb/tb.sv
// Testbench top for packet_class_interval_stats: clock, reset, packet stimulus with
// random idling, verdict. Depends on pcis_pkg, the block and pcis_checker.
`timescale 1ns / 100ps
module tb;
    import pcis_pkg::*;

    localparam int SLOTS = DEF_INTERVAL_SLOTS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_cap_len = '0;
    logic [15:0] s_wire_len = '0;
    logic [15:0] s_eth_type = '0;
    logic [7:0]  s_ip_proto = '0;
    logic [31:0] s_ts_sec = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_class_id;
    logic [3:0]  m_slot;
    logic [31:0] m_packets;
    logic [47:0] m_bytes;
    logic [15:0] m_min_len;
    logic [15:0] m_max_len;
    logic        m_last;
    int          fail_count;
    int          pending;
    logic        calm = 1'b0;
    int          idle_cycles = 0;
    logic [31:0] now_ts = 32'd1000;

    always #2 aclk = ~aclk;

    packet_class_interval_stats #(.INTERVAL_SLOTS(SLOTS)) u_dut (.*);

    pcis_checker #(.INTERVAL_SLOTS(SLOTS)) u_chk (.*);

    // sink: bursts of stall, then bursts of ready
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 7);
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
        end
    end

    // watchdog on accept-free cycles
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays high into the next request unless an idle burst comes between
    task automatic send_packet(logic [15:0] cap, logic [15:0] len, logic [15:0] et,
                               logic [7:0] proto, logic [31:0] ts);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cap_len <= cap;
        s_wire_len <= len;
        s_eth_type <= et;
        s_ip_proto <= proto;
        s_ts_sec <= ts;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        logic [15:0] cap, len, et;
        logic [7:0]  proto;
        logic [31:0] ts;
        int          pick;
        cap = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 40)) : 16'($urandom);
        len = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 1) ? 16'hFFFF : 0)
                                         : 16'($urandom);
        pick = $urandom_range(0, 9);
        et = pick < 5 ? ETYPE_IPV4 : pick < 8 ? ETYPE_IPV6 : 16'($urandom);
        pick = $urandom_range(0, 4);
        proto = pick < 2 ? PROTO_TCP : pick < 4 ? PROTO_UDP : 8'($urandom);
        // time mostly advances slowly; sometimes jumps, sometimes goes back
        pick = $urandom_range(0, 19);
        if (pick < 14) now_ts = now_ts + $urandom_range(0, 2);
        else if (pick < 17) now_ts = now_ts + $urandom_range(SLOTS, SLOTS + 5);
        else if (pick < 18) now_ts = now_ts + $urandom;
        ts = (pick == 19) ? now_ts - $urandom_range(1, 30) : now_ts;
        send_packet(cap, len, et, proto, ts);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: class boundaries, extremes, time before base, wrap of ts
        send_packet(16'd14, 16'd60, ETYPE_IPV4, PROTO_TCP, 32'd1000);
        send_packet(16'd15, 16'd0, ETYPE_IPV4, PROTO_TCP, 32'd1000);
        send_packet(16'd34, 16'd100, ETYPE_IPV4, PROTO_UDP, 32'd1001);
        send_packet(16'd35, 16'hFFFF, ETYPE_IPV4, PROTO_TCP, 32'd1002);
        send_packet(16'hFFFF, 16'd64, ETYPE_IPV4, PROTO_UDP, 32'd1009);
        send_packet(16'd35, 16'd70, ETYPE_IPV4, 8'hFF, 32'd1005);
        send_packet(16'd15, 16'd80, ETYPE_IPV6, PROTO_TCP, 32'd1003);
        send_packet(16'd14, 16'd90, ETYPE_IPV6, 8'd0, 32'd1003);
        send_packet(16'd200, 16'd90, 16'hFFFF, PROTO_UDP, 32'd1004);
        send_packet(16'd200, 16'd50, ETYPE_IPV4, PROTO_TCP, 32'd999);
        send_packet(16'd200, 16'd55, ETYPE_IPV6, 8'd0, 32'd1010);
        send_packet(16'd200, 16'd56, ETYPE_IPV4, PROTO_UDP, 32'd1019);
        send_packet(16'd200, 16'd57, ETYPE_IPV4, PROTO_TCP, 32'd1020);
        send_packet(16'd300, 16'd58, ETYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF);
        send_packet(16'd300, 16'd59, ETYPE_IPV6, 8'd0, 32'd5);
        send_packet(16'd300, 16'd61, ETYPE_IPV4, PROTO_UDP, 32'h0000_0000);
        send_packet(16'd300, 16'd62, 16'h0000, 8'd0, 32'd20);
        now_ts = 32'd20;

        for (int i = 0; i < 190; i++) begin
            if (i == 160) calm = 1'b1;
            send_random();
        end
        // flush the final interval
        send_packet(16'd60, 16'd60, ETYPE_IPV4, PROTO_TCP, now_ts + SLOTS);
        s_valid <= 1'b0;

        // let the checker take the last request before looking at its queue
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
design/pcis_pkg.sv
design/pcis_datapath.sv
design/pcis_ctrl.sv
design/packet_class_interval_stats.sv
tb/pcis_checker.sv
tb/tb.sv
